@@ sv/string_literal_unescape_top_defines.svh @@
// Assertion macros used by the checker file of the literal decoder.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef STRING_LITERAL_UNESCAPE_TOP_DEFINES_SVH
`define STRING_LITERAL_UNESCAPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SLU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ sv/slu_pkg.sv @@
// Shared types and codes for the string literal decoder.
// No dependencies; used by the step logic, the top level and the checker.
package slu_pkg;

   // Configuration reset: buffer size and the derived count limit.
   localparam logic [19:0] MAX_LEN_RESET = 20'd524288;
   localparam logic [19:0] LIMIT_RESET   = MAX_LEN_RESET - 20'd5;

   // Result status codes.
   localparam logic [2:0] ST_DATA = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_ESC  = 3'd2;
   localparam logic [2:0] ST_LONG = 3'd3;
   localparam logic [2:0] ST_TERM = 3'd4;

   // Decoder mode codes.
   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_BODY = 3'd1;
   localparam logic [2:0] M_ESC  = 3'd2;
   localparam logic [2:0] M_ZERO = 3'd3;
   localparam logic [2:0] M_HEX  = 3'd4;
   localparam logic [2:0] M_OCT  = 3'd5;
   localparam logic [2:0] M_BIN  = 3'd6;
   localparam logic [2:0] M_TER  = 3'd7;

   // Input word.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       starts_literal;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // Decoder state carried from one word to the next.
   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  escape_value;
      logic [1:0]  continuation_left;
      logic [19:0] out_count;
   } state_type;

   // Outcome of one input word: next state and up to two results.
   typedef struct packed {
      state_type  st;
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
   } work_type;

endpackage

@@ sv/slu_step.sv @@
// Combinational decode of one input word against the current decoder state.
// Depends on slu_pkg for the state, word and result types and the codes.
module slu_step
   import slu_pkg::*;
(
   input  state_type   state,
   input  req_type     req,
   input  logic [19:0] limit,
   output work_type    work
);

   // Append one result to the outcome.
   function automatic work_type put(work_type w, logic [7:0] b, logic [2:0] st,
                                    logic lst);
      rsp_type r;
      r.out_byte = b;
      r.status   = st;
      r.last     = lst;
      if (w.n == 2'd0) begin
         w.r0 = r;
      end else if (w.n == 2'd1) begin
         w.r1 = r;
      end
      if (w.n != 2'd2) begin
         w.n = w.n + 2'd1;
      end
      return w;
   endfunction

   // Final result of a literal; the decoder goes idle.
   function automatic work_type finish(work_type w, logic [2:0] st);
      w = put(w, 8'd0, st, 1'b1);
      w.st.mode              = M_IDLE;
      w.st.continuation_left = 2'd0;
      w.st.escape_value      = 8'd0;
      return w;
   endfunction

   // Count an output byte; reaching the limit replaces it with an error.
   function automatic work_type emit_data(work_type w, logic [7:0] b, logic [19:0] lim);
      w.st.out_count = w.st.out_count + 20'd1;
      if (w.st.out_count >= lim) begin
         w = finish(w, ST_LONG);
      end else begin
         w = put(w, b, ST_DATA, 1'b0);
      end
      return w;
   endfunction

   // A byte in the quotes: text (UTF-8 passes through), closing quote, backslash or NUL.
   function automatic work_type body_byte(work_type w, logic [7:0] b, logic [19:0] lim);
      logic [1:0] cl;
      cl = 2'd0;
      if (w.st.continuation_left != 2'd0) begin
         if (b == 8'h00) begin
            w = finish(w, ST_TERM);
         end else begin
            w.st.continuation_left = w.st.continuation_left - 2'd1;
            w = emit_data(w, b, lim);
         end
      end else if (b == 8'h00) begin
         w = finish(w, ST_TERM);
      end else if (b == 8'h22) begin
         w = finish(w, ST_DONE);
      end else if (b == 8'h5C) begin
         w.st.mode = M_ESC;
      end else begin
         if (b[7]) begin
            if ((b & 8'hE0) == 8'hC0) begin
               cl = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
               cl = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
               cl = 2'd3;
            end
         end
         w = emit_data(w, b, lim);
         if (w.st.mode == M_BODY) begin
            w.st.continuation_left = cl;
         end
      end
      return w;
   endfunction

   // Digit value of a hex character; 31 marks a non-digit.
   function automatic logic [4:0] digit_of(logic [7:0] b);
      logic [4:0] d;
      d = 5'd31;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = 5'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = 5'(b - 8'h41 + 8'd10);
      end
      return d;
   endfunction

   // One byte of a numeric escape in the given base.
   function automatic work_type run_byte(work_type w, logic [7:0] b, logic [4:0] base,
                                         logic [19:0] lim);
      logic [4:0]  d;
      logic [12:0] acc;
      d   = digit_of(b);
      acc = 13'(w.st.escape_value) * 13'(base) + 13'(d);
      if (d < base) begin
         w.st.escape_value = acc[7:0];
      end else begin
         w = emit_data(w, w.st.escape_value, lim);
         w.st.escape_value = 8'd0;
         if (w.st.mode != M_IDLE) begin
            w.st.mode = M_BODY;
            w = body_byte(w, b, lim);
         end
      end
      return w;
   endfunction

   // The character after a backslash.
   function automatic work_type escape_byte(work_type w, logic [7:0] b, logic [19:0] lim);
      logic [7:0] c;
      logic       lit;
      c   = 8'd0;
      lit = 1'b1;
      w.st.escape_value = 8'd0;
      case (b)
         8'h61: c = 8'd7;
         8'h62: c = 8'd8;
         8'h76: c = 8'd11;
         8'h66: c = 8'd12;
         8'h6E: c = 8'd10;
         8'h74: c = 8'd9;
         8'h5C: c = 8'h5C;
         8'h72: c = 8'd13;
         8'h22: c = 8'h22;
         8'h27: c = 8'h27;
         8'h75, 8'h78: begin
            w.st.mode = M_HEX;
            lit = 1'b0;
         end
         8'h30: begin
            w.st.mode = M_ZERO;
            lit = 1'b0;
         end
         default: begin
            w = finish(w, ST_ESC);
            lit = 1'b0;
         end
      endcase
      if (lit) begin
         w.st.mode = M_BODY;
         w = emit_data(w, c, lim);
      end
      return w;
   endfunction

   // Decode one word.
   always_comb begin
      work    = '0;
      work.st = state;
      if (req.starts_literal) begin
         work.st.continuation_left = 2'd0;
         work.st.escape_value      = 8'd0;
         work.st.out_count         = 20'd0;
         if (req.text_byte == 8'h22) begin
            work.st.mode = M_BODY;
         end else begin
            work = finish(work, ST_TERM);
         end
      end else begin
         case (state.mode)
            M_BODY: work = body_byte(work, req.text_byte, limit);
            M_ESC:  work = escape_byte(work, req.text_byte, limit);
            M_ZERO: begin
               if (req.text_byte == 8'h62) begin
                  work.st.mode = M_BIN;
               end else if (req.text_byte == 8'h63) begin
                  work.st.mode = M_TER;
               end else if (req.text_byte == 8'h78 || req.text_byte == 8'h58) begin
                  work.st.mode = M_HEX;
               end else begin
                  work.st.mode = M_OCT;
                  work = run_byte(work, req.text_byte, 5'd8, limit);
               end
            end
            M_HEX:  work = run_byte(work, req.text_byte, 5'd16, limit);
            M_OCT:  work = run_byte(work, req.text_byte, 5'd8, limit);
            M_BIN:  work = run_byte(work, req.text_byte, 5'd2, limit);
            M_TER:  work = run_byte(work, req.text_byte, 5'd3, limit);
            default: work.st.mode = M_IDLE;
         endcase
      end
   end

endmodule

@@ sv/string_literal_unescape_top.sv @@
// Top level of the string literal decoder: input register, step logic, result buffer.
// Depends on slu_pkg and slu_step.
//
// Usage:
// The req channel takes one source byte per word together with a flag that
// marks the opening quote of a new literal. The rsp channel gives decoded
// bytes and a final status word (done or an error) flagged with last.
// One word may give zero, one or two results.
// The csr port writes the buffer size at any edge with csr_we high; the user must
// write it only while no words are in flight, as the block does not enforce this.
// A word accepted into the input register is decoded from it and its results
// are registered in the result buffer, where they can be taken.
// Throughput: one word per cycle while each word gives at most one result and
// the receiver takes every result; a word giving two results can hold back the
// next word, since the result buffer drains one word per cycle.
// Reset (synchronous, active high) empties both registers, returns the decoder
// to idle and restores the buffer size to its reset value.
// When the receiver stalls, results wait in a two-entry buffer and req_ready
// drops once the pending word does not fit in the space left.
module string_literal_unescape_top
   import slu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [19:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff, in_in;
   state_type   state_ff, state_in;
   logic [19:0] limit_ff, limit_in;
   logic [1:0]  out_cnt_ff, out_cnt_in;
   rsp_type     out0_ff, out0_in;
   rsp_type     out1_ff, out1_in;

   work_type    work;
   logic        pop;
   logic        fire;
   logic        accept;
   logic [1:0]  remain;
   logic [2:0]  need;

   // Decode the registered word.
   slu_step u_step (
      .state (state_ff),
      .req   (in_ff),
      .limit (limit_ff),
      .work  (work)
   );

   // Handshake: decode when its results fit in the buffer after this cycle's pop.
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = out0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign remain    = out_cnt_ff - {1'b0, pop};
   assign need      = {1'b0, remain} + {1'b0, work.n};
   assign fire      = in_valid_ff && (need <= 3'd2);
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   // Input register next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Decoder state and count limit next values.
   always_comb begin
      state_in = fire ? work.st : state_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         limit_in = (csr_wdata >= 20'd5) ? csr_wdata - 20'd5 : 20'd0;
      end
   end

   // Result buffer: shift on pop, append the new results behind what remains.
   always_comb begin
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      out_cnt_in = remain;
      if (pop) begin
         out0_in = out1_ff;
      end
      if (fire) begin
         out_cnt_in = need[1:0];
         case (remain)
            2'd0: begin
               out0_in = work.r0;
               out1_in = work.r1;
            end
            2'd1: out1_in = work.r0;
            default: ;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_cnt_ff  <= 2'd0;
         state_ff    <= '{mode: M_IDLE, escape_value: 8'd0, continuation_left: 2'd0,
                          out_count: 20'd0};
         limit_ff    <= LIMIT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_cnt_ff  <= out_cnt_in;
         state_ff    <= state_in;
         limit_ff    <= limit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule

@@ sv/slu_checker.sv @@
// Port-level checks for the string literal decoder, bound to its top level.
// Depends on slu_pkg and the assertion macros in string_literal_unescape_top_defines.svh.
`include "string_literal_unescape_top_defines.svh"

module slu_checker
   import slu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result word holds.
   `SLU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Status codes stay in their range.
   `SLU_ASSERT_SAME(a_status_range, clock, reset, rsp_valid, rsp_data.status <= ST_TERM)

   // Only status words end a literal.
   `SLU_ASSERT_SAME(a_last_status, clock, reset, rsp_valid, rsp_data.last == (rsp_data.status != ST_DATA))

   // Status words carry a zero byte.
   `SLU_ASSERT_SAME(a_status_byte, clock, reset, rsp_valid && rsp_data.status != ST_DATA, rsp_data.out_byte == 8'd0)

   // With the result buffer empty the input is never blocked.
   `SLU_ASSERT_SAME(a_ready_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind string_literal_unescape_top slu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
